>>> rtl/icer_pkg.sv
// Shared types and register map constants for the interrupt controller.
// No dependencies.
`default_nettype none
package icer_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic        cpu_id;
        logic [14:0] reg_offset;
        logic [31:0] write_data;
        logic [7:0]  line_index;
        logic        line_level;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  cpu_irq;
    } t_out;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LINE  = 2'd2;

    localparam logic [14:0] OFF_INFO     = 15'h0004;
    localparam logic [14:0] OFF_CONFIG   = 15'h0010;
    localparam logic [14:0] OFF_WHOAMI   = 15'h2000;
    localparam logic [14:0] OFF_IPI_SEND = 15'h2008;
    localparam logic [14:0] OFF_IPI_ACK  = 15'h200c;
    localparam logic [14:0] OFF_IPI_MSET = 15'h2024;
    localparam logic [14:0] OFF_IPI_MCLR = 15'h2028;
    localparam logic [14:0] OFF_TARGET   = 15'h3000;
    localparam logic [14:0] OFF_WORDS    = 15'h4000;
    localparam logic [14:0] OFF_WORDS_END = 15'h4200;
    localparam logic [14:0] OFF_WINDOW   = 15'h5000;

    localparam logic [6:0] SUB_EVENT = 7'h04;
    localparam logic [6:0] SUB_SET   = 7'h08;
    localparam logic [6:0] SUB_ACK   = 7'h0c;
    localparam logic [6:0] SUB_MSET  = 7'h24;
    localparam logic [6:0] SUB_MCLR  = 7'h28;

    localparam logic [1:0] BANK_SW_SET   = 2'd0;
    localparam logic [1:0] BANK_SW_CLR   = 2'd1;
    localparam logic [1:0] BANK_MASK_SET = 2'd2;
    localparam logic [1:0] BANK_MASK_CLR = 2'd3;

    localparam logic [31:0] EV_HW        = 32'h0001_0000;
    localparam logic [31:0] EV_IPI_OTHER = 32'h0004_0001;
    localparam logic [31:0] EV_IPI_SELF  = 32'h0004_0002;

endpackage
`default_nettype wire

>>> rtl/icer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module icer_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/interrupt_controller_event_regs.sv
// Interrupt controller top level: register decode, line scan, event take.
// Depends on icer_pkg and icer_ram (pending/mask word RAM, target RAM).
// Sequence: S_RD, S_OP, a scan, then the S_DONE strobe; an event read adds S_TRD
// and a second scan, plus S_TWR when it takes a line. The scan
// reads one target entry per cycle. One transfer at a time, next accepted in the
// cycle after the strobe; receiver cannot stall. Reset: S_CLR clears every target entry and word, masking all lines.
`default_nettype none
module interrupt_controller_event_regs #(
    parameter int NUM_LINES = 192,
    parameter int NUM_CPUS  = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire icer_pkg::t_in  i_item,
    output logic                busy,
    output logic                o_done,
    output icer_pkg::t_out      o_result
);
    import icer_pkg::*;

    localparam int NUM_WORDS = (NUM_LINES + 31) / 32;
    localparam int WAW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW  = $clog2(NUM_LINES);
    localparam logic [IW-1:0] LAST = IW'(NUM_LINES - 1);
    localparam logic [15:0] TGT_END = 16'(32'h3000 + 4 * NUM_LINES);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_OP   = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_TRD  = 3'd5;
    localparam logic [2:0] S_TWR  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]          r_state;
    t_in                 r_it;
    logic [IW-1:0]       r_idx;
    logic                r_issue;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_take;
    logic [7:0]          r_ecpu;
    logic [NUM_CPUS-1:0] r_found;
    logic [IW-1:0]       r_first [NUM_CPUS];
    logic [31:0]         r_rd;
    logic [31:0]         r_ctrl;
    logic [NUM_CPUS-1:0] r_pend_o, r_pend_s, r_mask_o, r_mask_s;

    // word RAM holds {mask, soft, level}
    logic            w_we;
    logic [WAW-1:0]  w_waddr, w_raddr;
    logic [95:0]     w_wdata, w_rdata;
    logic            t_we;
    logic [IW-1:0]   t_waddr, t_raddr;
    logic [NUM_CPUS-1:0] t_wdata, t_rdata;

    icer_ram #(.WIDTH(96), .DEPTH(NUM_WORDS)) u_words (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    icer_ram #(.WIDTH(NUM_CPUS), .DEPTH(NUM_LINES)) u_targets (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    // decode of the latched access
    logic [14:0] off;
    logic [31:0] d;
    logic        is_tgt, is_wrd, wok, is_win, line_ok;
    logic [IW-1:0] tgt_idx;
    logic [4:0]  w5;
    logic [1:0]  bank;
    logic [14:0] win_off;
    logic [7:0]  win_cpu;
    logic [6:0]  sub;
    logic [31:0] lvl, sft, msk;
    logic [31:0] pend;

    always_comb begin
        off     = {r_it.reg_offset[14:2], 2'b00};
        d       = r_it.write_data;
        is_tgt  = (off >= OFF_TARGET) && ({1'b0, off} < TGT_END);
        tgt_idx = IW'((off - OFF_TARGET) >> 2);
        is_wrd  = (off >= OFF_WORDS) && (off < OFF_WORDS_END);
        w5      = off[6:2];
        wok     = 32'(w5) < NUM_WORDS;
        bank    = off[8:7];
        is_win  = off >= OFF_WINDOW;
        win_off = off - OFF_WINDOW;
        win_cpu = win_off[14:7];
        sub     = off[6:0];
        line_ok = 32'(r_it.line_index) < NUM_LINES;
        lvl     = w_rdata[31:0];
        sft     = w_rdata[63:32];
        msk     = w_rdata[95:64];
        pend    = (lvl | sft) & ~msk;
    end

    // event selection for the reading CPU
    logic          ecpu_ok, sel_found;
    logic [IW-1:0] sel_first;
    logic          sel_po, sel_ps, en;

    always_comb begin
        en        = r_ctrl[0];
        ecpu_ok   = 32'(r_ecpu) < NUM_CPUS;
        sel_found = 1'b0;
        sel_first = '0;
        sel_po    = 1'b0;
        sel_ps    = 1'b0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (r_ecpu == 8'(c)) begin
                sel_found = r_found[c];
                sel_first = r_first[c];
                sel_po    = r_pend_o[c] & ~r_mask_o[c];
                sel_ps    = r_pend_s[c] & ~r_mask_s[c];
            end
        end
    end

    // RAM ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = w_rdata;
        w_raddr = '0;
        t_we    = 1'b0;
        t_waddr = r_idx;
        t_wdata = '0;
        t_raddr = '0;
        unique case (r_state)
            S_CLR: begin
                t_we    = 1'b1;
                w_we    = 32'(r_idx) < NUM_WORDS;
                w_waddr = WAW'(r_idx);
                w_wdata = {32'hffff_ffff, 64'd0};
            end
            S_RD: begin
                w_raddr = (r_it.func == FUNC_LINE) ? WAW'(r_it.line_index >> 5) : WAW'(w5);
                t_raddr = tgt_idx;
            end
            S_OP: begin
                w_raddr = (r_it.func == FUNC_LINE) ? WAW'(r_it.line_index >> 5) : WAW'(w5);
                w_waddr = w_raddr;
                t_waddr = tgt_idx;
                t_wdata = d[NUM_CPUS-1:0];
                if (r_it.func == FUNC_WRITE) begin
                    t_we = is_tgt;
                    w_we = is_wrd && wok;
                    case (bank)
                        BANK_SW_SET:   w_wdata = {msk, sft | d, lvl};
                        BANK_SW_CLR:   w_wdata = {msk, sft & ~d, lvl};
                        BANK_MASK_SET: w_wdata = {msk | d, sft, lvl};
                        default:       w_wdata = {msk & ~d, sft, lvl};
                    endcase
                end else if (r_it.func == FUNC_LINE) begin
                    w_we = line_ok;
                    w_wdata = r_it.line_level
                        ? {msk, sft, lvl | (32'd1 << r_it.line_index[4:0])}
                        : {msk, sft, lvl & ~(32'd1 << r_it.line_index[4:0])};
                end
            end
            S_SCAN: begin
                w_raddr = WAW'(r_idx >> 5);
                t_raddr = r_idx;
            end
            S_TRD, S_TWR: begin
                w_raddr = WAW'(sel_first >> 5);
                w_waddr = w_raddr;
                w_we    = r_state == S_TWR;
                w_wdata = {msk | (32'd1 << sel_first[4:0]), sft, lvl};
            end
            default: ;
        endcase
    end

    logic scan_last;
    assign scan_last = r_pv && (r_pidx == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_issue  <= 1'b0;
            r_pv     <= 1'b0;
            r_take   <= 1'b0;
            r_ctrl   <= '0;
            r_pend_o <= '0;
            r_pend_s <= '0;
            r_mask_o <= '1;
            r_mask_s <= '1;
            r_found  <= '0;
        end else begin
            r_pv   <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_it    <= i_item;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_OP;
                S_OP: begin
                    r_rd    <= '0;
                    r_take  <= 1'b0;
                    r_ecpu  <= win_cpu;
                    r_idx   <= '0;
                    r_issue <= 1'b1;
                    r_found <= '0;
                    r_state <= S_SCAN;
                    if (r_it.func == FUNC_READ) begin
                        if (off == OFF_INFO) r_rd <= 32'(NUM_LINES & 16'hffff);
                        else if (off == OFF_CONFIG) r_rd <= r_ctrl;
                        else if (off == OFF_WHOAMI) r_rd <= 32'(r_it.cpu_id);
                        else if (is_tgt) r_rd <= 32'(t_rdata);
                        else if (is_wrd) r_rd <= !wok ? 32'd0 : (bank[1] ? msk : sft);
                        else if (is_win && sub == SUB_EVENT) r_take <= 1'b1;
                    end else if (r_it.func == FUNC_WRITE) begin
                        if (off == OFF_CONFIG) r_ctrl <= d;
                        for (int c = 0; c < NUM_CPUS; c++) begin
                            if (off == OFF_IPI_SEND) begin
                                if (d[c]) r_pend_o[c] <= 1'b1;
                                if (d[31] && r_it.cpu_id == 1'(c)) r_pend_s[c] <= 1'b1;
                            end else if ((!is_win && r_it.cpu_id == 1'(c)) ||
                                         (is_win && win_cpu == 8'(c))) begin
                                if ((!is_win && off == OFF_IPI_ACK) ||
                                    (is_win && sub == SUB_ACK)) begin
                                    if (d[0])  r_pend_o[c] <= 1'b0;
                                    if (d[31]) r_pend_s[c] <= 1'b0;
                                end else if ((!is_win && off == OFF_IPI_MSET) ||
                                             (is_win && sub == SUB_MSET)) begin
                                    if (d[0])  r_mask_o[c] <= 1'b1;
                                    if (d[31]) r_mask_s[c] <= 1'b1;
                                end else if ((!is_win && off == OFF_IPI_MCLR) ||
                                             (is_win && sub == SUB_MCLR)) begin
                                    if (d[0])  r_mask_o[c] <= 1'b0;
                                    if (d[31]) r_mask_s[c] <= 1'b0;
                                end else if (is_win && sub == SUB_SET) begin
                                    if (d[0])  r_pend_o[c] <= 1'b1;
                                    if (d[31]) r_pend_s[c] <= 1'b1;
                                end
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == LAST) r_issue <= 1'b0;
                    end
                    r_pv   <= r_issue;
                    r_pidx <= r_idx;
                    if (r_pv) begin
                        for (int c = 0; c < NUM_CPUS; c++) begin
                            if (!r_found[c] && t_rdata[c] && pend[r_pidx[4:0]]) begin
                                r_found[c] <= 1'b1;
                                r_first[c] <= r_pidx;
                            end
                        end
                    end
                    if (scan_last) begin
                        r_state <= r_take ? S_TRD : S_DONE;
                    end
                end
                S_TRD: begin
                    // final scan restarts here unless a line mask must be written
                    r_take  <= 1'b0;
                    r_idx   <= '0;
                    r_issue <= 1'b1;
                    r_found <= '0;
                    r_state <= S_SCAN;
                    if (en && ecpu_ok) begin
                        if (sel_found) begin
                            r_rd    <= EV_HW | 32'(sel_first);
                            r_found <= r_found;
                            r_issue <= 1'b0;
                            r_state <= S_TWR;
                        end else if (sel_po) begin
                            r_rd <= EV_IPI_OTHER;
                            for (int c = 0; c < NUM_CPUS; c++)
                                if (r_ecpu == 8'(c)) r_mask_o[c] <= 1'b1;
                        end else if (sel_ps) begin
                            r_rd <= EV_IPI_SELF;
                            for (int c = 0; c < NUM_CPUS; c++)
                                if (r_ecpu == 8'(c)) r_mask_s[c] <= 1'b1;
                        end
                    end
                end
                S_TWR: begin
                    r_idx   <= '0;
                    r_issue <= 1'b1;
                    r_found <= '0;
                    r_state <= S_SCAN;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [1:0] irq;
    always_comb begin
        irq = '0;
        for (int c = 0; c < NUM_CPUS && c < 2; c++) begin
            irq[c] = en & (r_found[c] | (r_pend_o[c] & ~r_mask_o[c]) |
                           (r_pend_s[c] & ~r_mask_s[c]));
        end
    end

    assign busy               = r_state != S_IDLE;
    assign o_done             = r_state == S_DONE;
    assign o_result.read_data = r_rd;
    assign o_result.cpu_irq   = irq;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done strobe longer than one cycle");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR || (r_state == S_SCAN && r_issue)) |-> 32'(r_idx) < NUM_LINES)
        else $error("scan index out of range");
    a_word_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> 32'(w_waddr) < NUM_WORDS) else $error("word write out of range");
    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_ctrl[0]) |-> o_result.cpu_irq == 2'b00)
        else $error("irq raised while disabled");
endmodule
`default_nettype wire
